// ----- design/tit_pkg.sv -----
// Package for the trickle interval timer: action codes, sequencer states
// and fixed constants. No dependencies.

package tit_pkg;

	// Action codes carried by an input item
	typedef enum logic [2:0] {
		ACT_TICK   = 3'd0,
		ACT_START  = 3'd1,
		ACT_STOP   = 3'd2,
		ACT_CONS   = 3'd3,
		ACT_INCONS = 3'd4
	} action_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MOD_SPAN,
		ST_HALF,
		ST_MOD_HALF,
		ST_DONE
	} state_t;

	// Configuration register indexes
	localparam logic [1:0] REG_MIN_INTERVAL   = 2'd0;
	localparam logic [1:0] REG_MAX_DOUBLINGS  = 2'd1;
	localparam logic [1:0] REG_REDUNDANCY_LIM = 2'd2;

	localparam int unsigned IMIN_W = 31;
	localparam int unsigned DBL_W  = 5;
	localparam int unsigned K_W    = 8;
	localparam int unsigned WORD_W = 32;

	localparam logic [IMIN_W-1:0] IMIN_FLOOR    = 31'd2;
	localparam logic [K_W-1:0]    COUNT_SAT     = 8'hFF;
	localparam logic [IMIN_W-1:0] IMIN_RESET    = 31'd2;
	localparam logic [DBL_W-1:0]  DBL_RESET     = 5'd1;
	localparam logic [K_W-1:0]    K_RESET       = 8'd1;

endpackage

// ----- design/trickle_interval_timer_top.sv -----
// Trickle interval timer (RFC 6206) top level: sequencer plus one shared
// restoring-remainder unit for the random picks. Depends on tit_pkg.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------
//  in      | sink      | in_valid / in_stall   | action, random_value
//  out     | source    | out_valid / out_stall | fire_now, transmit_allowed, running,
//          |           |                       | interval_now, heard_count
//  cfg     | sink      | cfg_we                | cfg_index, cfg_data
//
// Stop, consistent, unknown, plain tick items and an inconsistent item on a
// stopped timer go from the execute state straight to the done state. A tick
// that ends an interval or an inconsistent item on a running timer makes one
// random pick and a start makes two: each random pick runs 32 steps of the shared
// remainder unit, one dividend bit per cycle.
// Reset clears all timer state and loads the register defaults at once.
// A new item is accepted while a finished result still waits on out_stall;
// the block then holds in its last state until the output register frees.

module trickle_interval_timer_top (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [31:0] random_value,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        fire_now,
	output logic        transmit_allowed,
	output logic        running,
	output logic [31:0] interval_now,
	output logic [7:0]  heard_count,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data
);

	// control and timer state
	tit_pkg::state_t state_q, state_d;
	logic [30:0] min_int_q;
	logic [4:0]  max_dbl_q;
	logic [7:0]  k_q;
	logic [31:0] ilen_q, ilen_d;
	logic [31:0] imax_q, imax_d;
	logic [31:0] elapsed_q, elapsed_d;
	logic [31:0] fp_q, fp_d;
	logic [7:0]  count_q, count_d;
	logic        active_q, active_d;
	logic        fired_q, fired_d;
	logic        out_valid_q, out_valid_d;

	// item and remainder unit registers
	logic [2:0]  action_q, action_d;
	logic [31:0] rnd_q, rnd_d;
	logic [31:0] divisor_q, divisor_d;
	logic [31:0] rem_q, rem_d;
	logic [31:0] dvd_q, dvd_d;
	logic [4:0]  cnt_q, cnt_d;
	logic        fire_q, fire_d;
	logic        allowed_q, allowed_d;

	// output register
	logic        fire_now_q, fire_now_d;
	logic        allowed_out_q, allowed_out_d;
	logic        running_q, running_d;
	logic [31:0] interval_q, interval_d;
	logic [7:0]  heard_q, heard_d;

	// derived values
	logic [30:0] imin_eff;
	logic [62:0] imax_wide;
	logic [31:0] imax_calc;
	logic [31:0] span_calc;
	logic [31:0] elapsed_inc;
	logic [32:0] trial;
	logic [32:0] trial_diff;
	logic [31:0] rem_step;
	logic [30:0] half_raw;

	// Clamp Imin to two and form the latched Imax with a 32-bit ceiling
	assign imin_eff  = (min_int_q < tit_pkg::IMIN_FLOOR) ? tit_pkg::IMIN_FLOOR : min_int_q;
	assign imax_wide = {32'd0, imin_eff} << max_dbl_q;
	assign imax_calc = (|imax_wide[62:32]) ? 32'hFFFF_FFFF : imax_wide[31:0];
	assign span_calc = imax_calc - {1'b0, imin_eff} + 32'd1;

	// Saturating tick count
	assign elapsed_inc = (elapsed_q != 32'hFFFF_FFFF) ? (elapsed_q + 32'd1) : elapsed_q;

	// One restoring remainder step: shift in the next dividend bit, subtract if it fits
	assign trial      = {rem_q, dvd_q[31]};
	assign trial_diff = trial - {1'b0, divisor_q};
	assign rem_step   = (trial >= {1'b0, divisor_q}) ? trial_diff[31:0] : trial[31:0];

	assign half_raw = ilen_q[31:1];

	// Next state and datapath
	always_comb begin
		state_d       = state_q;
		ilen_d        = ilen_q;
		imax_d        = imax_q;
		elapsed_d     = elapsed_q;
		fp_d          = fp_q;
		count_d       = count_q;
		active_d      = active_q;
		fired_d       = fired_q;
		out_valid_d   = out_valid_q;
		action_d      = action_q;
		rnd_d         = rnd_q;
		divisor_d     = divisor_q;
		rem_d         = rem_q;
		dvd_d         = dvd_q;
		cnt_d         = cnt_q;
		fire_d        = fire_q;
		allowed_d     = allowed_q;
		fire_now_d    = fire_now_q;
		allowed_out_d = allowed_out_q;
		running_d     = running_q;
		interval_d    = interval_q;
		heard_d       = heard_q;

		// drop the result once taken
		if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			tit_pkg::ST_IDLE: begin
				if (in_valid) begin
					action_d = action;
					rnd_d    = random_value;
					state_d  = tit_pkg::ST_EXEC;
				end
			end
			tit_pkg::ST_EXEC: begin
				fire_d    = 1'b0;
				allowed_d = 1'b0;
				state_d   = tit_pkg::ST_DONE;
				case (action_q)
					tit_pkg::ACT_TICK: begin
						if (active_q) begin
							elapsed_d = elapsed_inc;
							if (!fired_q && elapsed_inc == fp_q) begin
								fired_d   = 1'b1;
								fire_d    = 1'b1;
								allowed_d = (k_q == 8'd0) || (count_q < k_q);
							end else if (elapsed_inc >= ilen_q) begin
								// interval end: double up to Imax, then pick a new fire point
								ilen_d  = (ilen_q <= {1'b0, imax_q[31:1]}) ?
								          {ilen_q[30:0], 1'b0} : imax_q;
								state_d = tit_pkg::ST_HALF;
							end
						end
					end
					tit_pkg::ACT_START: begin
						imax_d    = imax_calc;
						divisor_d = span_calc;
						rem_d     = 32'd0;
						dvd_d     = rnd_q;
						cnt_d     = 5'd31;
						state_d   = tit_pkg::ST_MOD_SPAN;
					end
					tit_pkg::ACT_STOP: begin
						active_d = 1'b0;
						ilen_d   = 32'd0;
					end
					tit_pkg::ACT_CONS: begin
						if (count_q != tit_pkg::COUNT_SAT) begin
							count_d = count_q + 8'd1;
						end
					end
					tit_pkg::ACT_INCONS: begin
						if (active_q) begin
							ilen_d  = {1'b0, imin_eff};
							state_d = tit_pkg::ST_HALF;
						end
					end
					default: begin
					end
				endcase
			end
			tit_pkg::ST_MOD_SPAN: begin
				rem_d = rem_step;
				dvd_d = {dvd_q[30:0], 1'b0};
				cnt_d = cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					ilen_d  = {1'b0, imin_eff} + rem_step;
					state_d = tit_pkg::ST_HALF;
				end
			end
			tit_pkg::ST_HALF: begin
				// fire point lies in [half, I); half is at least one
				divisor_d = (half_raw == 31'd0) ? 32'd1 : {1'b0, half_raw};
				rem_d     = 32'd0;
				dvd_d     = rnd_q;
				cnt_d     = 5'd31;
				state_d   = tit_pkg::ST_MOD_HALF;
			end
			tit_pkg::ST_MOD_HALF: begin
				rem_d = rem_step;
				dvd_d = {dvd_q[30:0], 1'b0};
				cnt_d = cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					count_d   = 8'd0;
					fp_d      = divisor_q + rem_step;
					elapsed_d = 32'd0;
					fired_d   = 1'b0;
					active_d  = 1'b1;
					state_d   = tit_pkg::ST_DONE;
				end
			end
			tit_pkg::ST_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					out_valid_d   = 1'b1;
					fire_now_d    = fire_q;
					allowed_out_d = allowed_q;
					running_d     = active_q;
					interval_d    = ilen_q;
					heard_d       = count_q;
					state_d       = tit_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tit_pkg::ST_IDLE;
			end
		endcase
	end

	// Control and timer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tit_pkg::ST_IDLE;
			min_int_q   <= tit_pkg::IMIN_RESET;
			max_dbl_q   <= tit_pkg::DBL_RESET;
			k_q         <= tit_pkg::K_RESET;
			ilen_q      <= 32'd0;
			imax_q      <= 32'd0;
			elapsed_q   <= 32'd0;
			fp_q        <= 32'd0;
			count_q     <= 8'd0;
			active_q    <= 1'b0;
			fired_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ilen_q      <= ilen_d;
			imax_q      <= imax_d;
			elapsed_q   <= elapsed_d;
			fp_q        <= fp_d;
			count_q     <= count_d;
			active_q    <= active_d;
			fired_q     <= fired_d;
			out_valid_q <= out_valid_d;
			if (cfg_we) begin
				case (cfg_index)
					tit_pkg::REG_MIN_INTERVAL:   min_int_q <= cfg_data;
					tit_pkg::REG_MAX_DOUBLINGS:  max_dbl_q <= cfg_data[4:0];
					tit_pkg::REG_REDUNDANCY_LIM: k_q       <= cfg_data[7:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		action_q      <= action_d;
		rnd_q         <= rnd_d;
		divisor_q     <= divisor_d;
		rem_q         <= rem_d;
		dvd_q         <= dvd_d;
		cnt_q         <= cnt_d;
		fire_q        <= fire_d;
		allowed_q     <= allowed_d;
		fire_now_q    <= fire_now_d;
		allowed_out_q <= allowed_out_d;
		running_q     <= running_d;
		interval_q    <= interval_d;
		heard_q       <= heard_d;
	end

	assign in_stall         = (state_q != tit_pkg::ST_IDLE);
	assign out_valid        = out_valid_q;
	assign fire_now         = fire_now_q;
	assign transmit_allowed = allowed_out_q;
	assign running          = running_q;
	assign interval_now     = interval_q;
	assign heard_count      = heard_q;

`ifndef SYNTH
	// Between items a running timer always has its fire point inside the interval
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tit_pkg::ST_IDLE && active_q) |-> (fp_q < ilen_q))
		else $error("fire point not below interval length");

	// The remainder unit never holds a partial remainder at or above its divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tit_pkg::ST_MOD_SPAN || state_q == tit_pkg::ST_MOD_HALF)
		|-> (rem_q < divisor_q))
		else $error("partial remainder out of range");

	// A transmit permission only comes with a fire on a running timer
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((!transmit_allowed || fire_now) && (!fire_now || running)))
		else $error("transmit permission without a fire");

	// An accepted item always leaves the idle state on the next edge
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == tit_pkg::ST_EXEC))
		else $error("accepted item not executed");
`endif

endmodule

// ----- bench/trickle_interval_timer_top_tb.sv -----
// Self-checking bench for trickle_interval_timer_top: queued item driver, result
// monitor and a cycle-free predictor of the trickle timer, over several settings.
// Depends on tit_pkg and the top level only.

module trickle_interval_timer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] ACT_RSVD_FIRST = 3'd5;
	localparam logic [2:0] ACT_RSVD_LAST  = 3'd7;
	localparam int MAX_WAIT       = 14;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [2:0]  act;
		logic [31:0] rnd;
	} timer_item_t;

	typedef struct packed {
		logic        fire;
		logic        allowed;
		logic        run;
		logic [31:0] interval;
		logic [7:0]  heard;
	} timer_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  action = '0;
	logic [31:0] random_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        fire_now;
	logic        transmit_allowed;
	logic        running;
	logic [31:0] interval_now;
	logic [7:0]  heard_count;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [30:0] cfg_data = '0;

	// items waiting to be driven and results still owed by the block
	timer_item_t   pending_items[$];
	timer_result_t owed_results[$];

	// predictor state and its copy of the registers
	logic [31:0] iv_len = '0;
	logic [31:0] iv_max = '0;
	logic [31:0] ticks_in_iv = '0;
	logic [31:0] fire_pt = '0;
	logic [7:0]  heard_cnt = '0;
	logic        timer_on = 1'b0;
	logic        fired = 1'b0;
	logic [30:0] cfg_imin = tit_pkg::IMIN_RESET;
	logic [4:0]  cfg_dbl = tit_pkg::DBL_RESET;
	logic [7:0]  cfg_k = tit_pkg::K_RESET;

	bit sender_idle_on = 1'b1;
	bit receiver_idle_on = 1'b1;
	int send_wait = 0;
	int recv_wait = 0;
	int idle_cycles = 0;
	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int settings_used = 0;
	int fire_count = 0;
	int allowed_count = 0;
	int rollovers = 0;

	trickle_interval_timer_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.random_value(random_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.fire_now(fire_now),
		.transmit_allowed(transmit_allowed),
		.running(running),
		.interval_now(interval_now),
		.heard_count(heard_count),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] imin_floor();
		return (cfg_imin < tit_pkg::IMIN_FLOOR) ? 32'(tit_pkg::IMIN_FLOOR) : 32'(cfg_imin);
	endfunction

	// pick the fire point in the second half of the interval and clear c
	function automatic void open_interval(logic [31:0] rnd);
		logic [31:0] half;
		half = iv_len >> 1;
		if (half == 0)
			half = 1;
		heard_cnt = '0;
		fire_pt = half + (rnd % half);
		ticks_in_iv = '0;
		fired = 1'b0;
		timer_on = 1'b1;
	endfunction

	// advance the timer by one item and return the status it reports
	function automatic timer_result_t advance_timer(logic [2:0] act, logic [31:0] rnd);
		timer_result_t r;
		logic [63:0] lo;
		logic [63:0] hi;
		r = '0;
		case (act)
			tit_pkg::ACT_TICK: begin
				if (timer_on) begin
					if (ticks_in_iv != '1)
						ticks_in_iv++;
					if (!fired && ticks_in_iv == fire_pt) begin
						fired = 1'b1;
						r.fire = 1'b1;
						r.allowed = (cfg_k == 0 || heard_cnt < cfg_k);
						fire_count++;
						if (r.allowed)
							allowed_count++;
					end else if (ticks_in_iv >= iv_len) begin
						if (iv_len <= (iv_max >> 1))
							iv_len = iv_len << 1;
						else
							iv_len = iv_max;
						open_interval(rnd);
						rollovers++;
					end
				end
			end
			tit_pkg::ACT_START: begin
				lo = 64'(imin_floor());
				hi = lo << cfg_dbl;
				if (hi > 64'hFFFF_FFFF)
					hi = 64'hFFFF_FFFF;
				iv_max = hi[31:0];
				iv_len = 32'(lo + ({32'd0, rnd} % (hi - lo + 1)));
				open_interval(rnd);
			end
			tit_pkg::ACT_STOP: begin
				timer_on = 1'b0;
				iv_len = '0;
			end
			tit_pkg::ACT_CONS: begin
				if (heard_cnt != tit_pkg::COUNT_SAT)
					heard_cnt++;
			end
			tit_pkg::ACT_INCONS: begin
				if (timer_on) begin
					iv_len = imin_floor();
					open_interval(rnd);
				end
			end
			default: ;
		endcase
		r.run = timer_on;
		r.interval = iv_len;
		r.heard = heard_cnt;
		return r;
	endfunction

	// present queued items; predict each one as it is accepted
	always @(posedge clk) begin : drive_items
		logic next_valid;
		timer_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			next_valid = in_valid;
			if (in_valid && !in_stall) begin
				owed_results.push_back(advance_timer(action, random_value));
				items_sent++;
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (pending_items.size() > 0) begin
					nxt = pending_items.pop_front();
					action <= nxt.act;
					random_value <= nxt.rnd;
					next_valid = 1'b1;
					send_wait = sender_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
				end
			end
			in_valid <= next_valid;
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// take results, compare with the oldest prediction, then stall at random
	always @(posedge clk) begin : check_results
		timer_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					$display("%0t: result with no item outstanding", $time);
					mismatches++;
				end else begin
					want = owed_results.pop_front();
					check_field("fire_now", 32'(want.fire), 32'(fire_now));
					check_field("transmit_allowed", 32'(want.allowed), 32'(transmit_allowed));
					check_field("running", 32'(want.run), 32'(running));
					check_field("interval_now", want.interval, interval_now);
					check_field("heard_count", 32'(want.heard), 32'(heard_count));
				end
				results_seen++;
				recv_wait = receiver_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			out_stall <= (recv_wait > 0);
		end
	end

	// end the run if neither channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic queue_item(logic [2:0] act, logic [31:0] rnd);
		pending_items.push_back('{act: act, rnd: rnd});
	endtask

	task automatic wait_drained(int settle);
		do
			@(negedge clk);
		while (pending_items.size() != 0 || in_valid || owed_results.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	// drain, then load all three registers and the idling mode of the next run
	task automatic begin_phase(logic [30:0] imin, logic [4:0] dbl, logic [7:0] k,
			bit s_idle, bit r_idle);
		wait_drained(SETTLE_CYCLES);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= tit_pkg::REG_MIN_INTERVAL;
		cfg_data <= imin;
		@(posedge clk);
		cfg_index <= tit_pkg::REG_MAX_DOUBLINGS;
		cfg_data <= 31'(dbl);
		@(posedge clk);
		cfg_index <= tit_pkg::REG_REDUNDANCY_LIM;
		cfg_data <= 31'(k);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_imin = imin;
		cfg_dbl = dbl;
		cfg_k = k;
		sender_idle_on = s_idle;
		receiver_idle_on = r_idle;
		settings_used++;
		@(negedge clk);
	endtask

	// mostly start-then-tick sequences, with heard messages, restarts and noise
	task automatic queue_random_run(int target);
		int counted;
		int pick;
		bit live;
		logic [2:0] act;
		counted = 0;
		live = timer_on;
		while (counted < target) begin
			pick = $urandom_range(0, 99);
			if (!live) begin
				if (pick < 60)      act = tit_pkg::ACT_START;
				else if (pick < 75) act = tit_pkg::ACT_TICK;
				else if (pick < 85) act = tit_pkg::ACT_CONS;
				else if (pick < 92) act = tit_pkg::ACT_INCONS;
				else if (pick < 96) act = tit_pkg::ACT_STOP;
				else                act = 3'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
			end else begin
				if (pick < 68)      act = tit_pkg::ACT_TICK;
				else if (pick < 80) act = tit_pkg::ACT_CONS;
				else if (pick < 86) act = tit_pkg::ACT_INCONS;
				else if (pick < 90) act = tit_pkg::ACT_START;
				else if (pick < 94) act = tit_pkg::ACT_STOP;
				else                act = 3'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
			end
			queue_item(act, $urandom());
			if (act == tit_pkg::ACT_CONS || act == tit_pkg::ACT_START
					|| (live && act != tit_pkg::ACT_STOP && act < ACT_RSVD_FIRST)
					|| (live && act == tit_pkg::ACT_STOP))
				counted++;
			if (act == tit_pkg::ACT_START)
				live = 1'b1;
			else if (act == tit_pkg::ACT_STOP)
				live = 1'b0;
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// stopped-timer cases, reserved actions, restart, suppression, reset to Imin
		queue_item(tit_pkg::ACT_TICK, $urandom());
		queue_item(tit_pkg::ACT_CONS, $urandom());
		queue_item(tit_pkg::ACT_INCONS, $urandom());
		queue_item(tit_pkg::ACT_STOP, $urandom());
		queue_item(ACT_RSVD_FIRST, 32'hFFFF_FFFF);
		queue_item(3'(ACT_RSVD_FIRST + 1), $urandom());
		queue_item(ACT_RSVD_LAST, 32'h0);
		queue_item(tit_pkg::ACT_START, 32'hFFFF_FFFF);
		queue_item(tit_pkg::ACT_TICK, $urandom());
		queue_item(tit_pkg::ACT_TICK, $urandom());
		queue_item(tit_pkg::ACT_START, 32'hFFFF_FFFE);
		queue_item(tit_pkg::ACT_CONS, $urandom());
		queue_item(tit_pkg::ACT_CONS, $urandom());
		repeat (4) queue_item(tit_pkg::ACT_TICK, $urandom());
		queue_item(tit_pkg::ACT_INCONS, 32'hFFFF_FFFF);
		queue_item(tit_pkg::ACT_TICK, 32'h0);
		queue_item(tit_pkg::ACT_TICK, $urandom());
		queue_item(tit_pkg::ACT_STOP, $urandom());
		queue_item(tit_pkg::ACT_TICK, $urandom());

		// infinite k, small Imin
		begin_phase(31'd3, 5'd3, 8'd0, 1'b1, 1'b0);
		queue_random_run(150);

		// Imin below the floor, no doublings, largest k
		begin_phase(31'd0, 5'd0, 8'd255, 1'b0, 1'b1);
		queue_random_run(120);

		// Imin below the floor with the most doublings: Imax clamps
		begin_phase(31'd1, 5'd31, 8'd2, 1'b1, 1'b1);
		queue_random_run(40);

		// largest Imin, clamped Imax
		begin_phase(31'h7FFF_FFFF, 5'd30, 8'd1, 1'b0, 1'b0);
		queue_random_run(30);

		// latch a small Imax, then raise Imin above it and hear an inconsistency
		begin_phase(31'd2, 5'd2, 8'd3, 1'b1, 1'b1);
		queue_item(tit_pkg::ACT_START, $urandom());
		repeat (3) queue_item(tit_pkg::ACT_TICK, $urandom());
		begin_phase(31'd40, 5'd2, 8'd3, 1'b1, 1'b1);
		queue_item(tit_pkg::ACT_INCONS, $urandom());
		repeat (45) queue_item(tit_pkg::ACT_TICK, $urandom());
		queue_item(tit_pkg::ACT_STOP, $urandom());

		// random small settings, every idling mix
		for (int i = 0; i < 7; i++) begin
			begin_phase(31'($urandom_range(2, 6)), 5'($urandom_range(1, 5)),
				8'($urandom_range(0, 4)), i[0], i[1]);
			queue_random_run(130);
		end

		wait_drained(TAIL_CYCLES);
		$display("Covered %0d items and %0d results under %0d register settings;",
			items_sent, results_seen, settings_used);
		$display("saw %0d fire points (%0d allowed) and %0d interval rollovers.",
			fire_count, allowed_count, rollovers);
		if (mismatches == 0 && owed_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
